// ===== rtl/per_owner_event_pool_top_assert.svh =====
// assertion macros used by the event pool datapath
`ifndef PER_OWNER_EVENT_POOL_TOP_ASSERT_SVH
`define PER_OWNER_EVENT_POOL_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// implication property checked at every clock edge outside reset
`define PEP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition that must never hold outside reset
`define PEP_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define PEP_ASSERT(lbl, clk, rstn, prop, msg)
`define PEP_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ===== rtl/pep_pkg.sv =====
// types and constants of the per-owner event pool
package pep_pkg;
  localparam int POOL_SLOTS  = 16;
  localparam int OWNER_COUNT = 4;
  localparam int ID_LIMIT    = 16;
  localparam int DATA_WIDTH  = 32;

  localparam int REQ_W   = 2;
  localparam int OWN_W   = 2;
  localparam int SLOT_W  = 4;
  localparam int ID_W    = 4;
  localparam int STAT_W  = 3;
  localparam int PAY_W   = 32;
  localparam int CNT_W   = $clog2(ID_LIMIT + 1);
  localparam int ENTRY_W = OWN_W + ID_W + DATA_WIDTH;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_GET    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 3'd0,
    ST_LIMIT = 3'd1,
    ST_FULL  = 3'd2,
    ST_NONE  = 3'd3,
    ST_FREE  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_FETCH,
    S_FWAIT,
    S_COMMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_step;
    logic fetch;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic early;
    logic is_remove;
    logic is_get;
    logic scan_last;
    logic out_free;
  } sts_t;
endpackage

// ===== rtl/pep_in_if.sv =====
// request channel
interface pep_in_if;
  logic                     valid;
  logic                     ready;
  logic [pep_pkg::REQ_W-1:0]  req_type;
  logic [pep_pkg::OWN_W-1:0]  owner;
  logic [pep_pkg::PAY_W-1:0]  payload;
  logic [pep_pkg::SLOT_W-1:0] slot;
  modport source (output valid, req_type, owner, payload, slot, input ready);
  modport sink (input valid, req_type, owner, payload, slot, output ready);
endinterface

// ===== rtl/pep_out_if.sv =====
// result channel
interface pep_out_if;
  logic                      valid;
  logic                      ready;
  logic [pep_pkg::STAT_W-1:0] status;
  logic [pep_pkg::ID_W-1:0]   event_id;
  logic [pep_pkg::PAY_W-1:0]  event_payload;
  modport source (output valid, status, event_id, event_payload, input ready);
  modport sink (input valid, status, event_id, event_payload, output ready);
endinterface

// ===== rtl/pep_ram.sv =====
// generic single-port-write ram with registered read
module pep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== rtl/pep_ctrl.sv =====
// sequencer for check, slot scan, fetch and commit of one request
module pep_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pep_pkg::sts_t sts,
  output pep_pkg::cmd_t cmd
);
  import pep_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.early) state_nxt = S_COMMIT;
        else if (sts.is_remove) state_nxt = S_FWAIT;
        else state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = sts.is_get ? S_FETCH : S_COMMIT;
      end
      S_FETCH:  state_nxt = S_FWAIT;
      S_FWAIT:  state_nxt = S_COMMIT;
      S_COMMIT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_CHECK: begin
        cmd.scan_clr = 1'b1;
        cmd.fetch    = !sts.early && sts.is_remove;
      end
      S_SCAN:   cmd.scan_step = 1'b1;
      S_FETCH:  cmd.fetch = 1'b1;
      S_COMMIT: cmd.commit = sts.out_free;
      default:  cmd = '0;
    endcase
  end
endmodule

// ===== rtl/pep_dpath.sv =====
// pool state, slot store, scan accumulators and result register
module pep_dpath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pep_pkg::cmd_t              cmd,
  output pep_pkg::sts_t              sts,
  input  logic [pep_pkg::REQ_W-1:0]  in_req_type,
  input  logic [pep_pkg::OWN_W-1:0]  in_owner,
  input  logic [pep_pkg::PAY_W-1:0]  in_payload,
  input  logic [pep_pkg::SLOT_W-1:0] in_slot,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pep_pkg::STAT_W-1:0] out_status,
  output logic [pep_pkg::ID_W-1:0]   out_event_id,
  output logic [pep_pkg::PAY_W-1:0]  out_event_payload
);
  import pep_pkg::*;
  `include "per_owner_event_pool_top_assert.svh"

  // latched request
  req_t              req_r;
  logic [OWN_W-1:0]  own_r;
  logic [PAY_W-1:0]  pay_r;
  logic [SLOT_W-1:0] slot_r;

  // pool bookkeeping
  logic [POOL_SLOTS-1:0] used_r, used_nxt;
  logic [CNT_W-1:0]      cnt_r [OWNER_COUNT];
  logic [CNT_W-1:0]      cnt_nxt [OWNER_COUNT];
  logic [ID_W-1:0]       cur_r [OWNER_COUNT];
  logic [ID_W-1:0]       cur_nxt [OWNER_COUNT];

  // scan
  logic [SLOT_W-1:0] scan_cnt_r;
  logic              acc_vld_r;
  logic [SLOT_W-1:0] acc_idx_r;
  logic              a_vld_r, b_vld_r;
  logic [ID_W-1:0]   a_id_r, b_id_r;
  logic [SLOT_W-1:0] a_slot_r, b_slot_r;

  // result register
  logic              out_valid_r;
  status_t           out_status_r;
  logic [ID_W-1:0]   out_id_r;
  logic [PAY_W-1:0]  out_pay_r;

  // ram ports
  logic              ram_we, ram_re;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [OWN_W-1:0]  e_own;
  logic [ID_W-1:0]   e_id;
  logic [DATA_WIDTH-1:0] e_dat;

  logic              any_free;
  logic [SLOT_W-1:0] free_loc;
  logic              early;
  status_t           early_stat;
  logic [ID_W-1:0]   cur;
  logic              hit, in_hi;
  logic [ID_W-1:0]   new_id;
  logic              found;
  logic [SLOT_W-1:0] sel_slot;
  logic              cnt_dec_en;
  logic [OWN_W-1:0]  cnt_dec_own;

  assign e_own = ram_rdata[ENTRY_W-1 -: OWN_W];
  assign e_id  = ram_rdata[DATA_WIDTH +: ID_W];
  assign e_dat = ram_rdata[DATA_WIDTH-1:0];
  assign cur   = cur_r[own_r];

  // first free slot
  always_comb begin
    any_free = 1'b0;
    free_loc = '0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        any_free = 1'b1;
        free_loc = SLOT_W'(i);
      end
    end
  end

  // request checks that end without a scan
  always_comb begin
    early      = 1'b0;
    early_stat = ST_OK;
    case (req_r)
      REQ_INSERT: begin
        if (32'(own_r) >= OWNER_COUNT || 32'(cnt_r[own_r]) >= ID_LIMIT) begin
          early = 1'b1; early_stat = ST_LIMIT;
        end else if (!any_free) begin
          early = 1'b1; early_stat = ST_FULL;
        end
      end
      REQ_GET: begin
        if (32'(own_r) >= OWNER_COUNT || cnt_r[own_r] == '0) begin
          early = 1'b1; early_stat = ST_NONE;
        end
      end
      REQ_REMOVE: begin
        if (32'(slot_r) >= POOL_SLOTS || !used_r[slot_r]) begin
          early = 1'b1; early_stat = ST_FREE;
        end
      end
      default: begin
        early = 1'b1; early_stat = ST_OK;
      end
    endcase
  end

  assign sts.early     = early;
  assign sts.is_remove = (req_r == REQ_REMOVE);
  assign sts.is_get    = (req_r == REQ_GET);
  assign sts.scan_last = (32'(scan_cnt_r) == POOL_SLOTS - 1);
  assign sts.out_free  = !out_valid_r || out_ready;

  // get picks lowest id at or above cursor, else lowest overall
  assign found    = a_vld_r || b_vld_r;
  assign sel_slot = a_vld_r ? a_slot_r : b_slot_r;

  // insert id: above highest at/after cursor, else wrap below cursor
  always_comb begin
    if (!a_vld_r) new_id = '0;
    else if (32'(a_id_r) != ID_LIMIT - 1) new_id = a_id_r + 1'b1;
    else if (b_vld_r) new_id = b_id_r + 1'b1;
    else new_id = '0;
  end

  // ram access
  assign ram_re    = cmd.scan_step || cmd.fetch;
  assign ram_raddr = cmd.scan_step ? scan_cnt_r :
                     (req_r == REQ_REMOVE) ? slot_r : sel_slot;
  assign ram_we    = cmd.commit && !early && (req_r == REQ_INSERT);
  assign ram_waddr = free_loc;
  assign ram_wdata = {own_r, new_id, DATA_WIDTH'(pay_r)};

  pep_ram #(.WIDTH(ENTRY_W), .DEPTH(POOL_SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= req_t'(in_req_type);
      own_r  <= in_owner;
      pay_r  <= in_payload;
      slot_r <= in_slot;
    end
  end

  // scan counter and read tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= 1'b0;
    end else begin
      acc_vld_r <= cmd.scan_step;
    end
    acc_idx_r <= scan_cnt_r;
    if (cmd.scan_clr) scan_cnt_r <= '0;
    else if (cmd.scan_step) scan_cnt_r <= scan_cnt_r + 1'b1;
  end

  // scan accumulators
  assign hit   = acc_vld_r && used_r[acc_idx_r] && (e_own == own_r);
  assign in_hi = (e_id >= cur);

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else if (hit) begin
      if (req_r == REQ_INSERT) begin
        if (in_hi && (!a_vld_r || e_id > a_id_r)) begin
          a_vld_r <= 1'b1; a_id_r <= e_id; a_slot_r <= acc_idx_r;
        end
        if (!in_hi && (!b_vld_r || e_id > b_id_r)) begin
          b_vld_r <= 1'b1; b_id_r <= e_id; b_slot_r <= acc_idx_r;
        end
      end else begin
        if (in_hi && (!a_vld_r || e_id < a_id_r)) begin
          a_vld_r <= 1'b1; a_id_r <= e_id; a_slot_r <= acc_idx_r;
        end
        if (!b_vld_r || e_id < b_id_r) begin
          b_vld_r <= 1'b1; b_id_r <= e_id; b_slot_r <= acc_idx_r;
        end
      end
    end
  end

  // commit: bookkeeping next values
  always_comb begin
    used_nxt    = used_r;
    cur_nxt     = cur_r;
    cnt_nxt     = cnt_r;
    cnt_dec_en  = 1'b0;
    cnt_dec_own = e_own;
    if (cmd.commit && !early) begin
      case (req_r)
        REQ_INSERT: begin
          used_nxt[free_loc] = 1'b1;
          cnt_nxt[own_r]     = cnt_r[own_r] + 1'b1;
        end
        REQ_GET: begin
          if (found) begin
            if (!a_vld_r) cur_nxt[own_r] = '0;
            else if (32'(cur) == ID_LIMIT - 1) cur_nxt[own_r] = '0;
            else cur_nxt[own_r] = cur + 1'b1;
            used_nxt[sel_slot] = 1'b0;
            cnt_dec_en = 1'b1;
          end
        end
        REQ_REMOVE: begin
          used_nxt[slot_r] = 1'b0;
          cnt_dec_en = 1'b1;
        end
        default: cnt_dec_en = 1'b0;
      endcase
      if (cnt_dec_en && 32'(cnt_dec_own) < OWNER_COUNT && cnt_r[cnt_dec_own] != '0) begin
        cnt_nxt[cnt_dec_own] = cnt_r[cnt_dec_own] - 1'b1;
      end
    end
  end

  // bookkeeping registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      for (int i = 0; i < OWNER_COUNT; i++) begin
        cnt_r[i] <= '0;
        cur_r[i] <= '0;
      end
    end else begin
      used_r <= used_nxt;
      cnt_r  <= cnt_nxt;
      cur_r  <= cur_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.commit) begin
      out_status_r <= early_stat;
      out_id_r     <= '0;
      out_pay_r    <= '0;
      if (!early) begin
        case (req_r)
          REQ_INSERT: out_id_r <= new_id;
          REQ_GET: begin
            if (found) begin
              out_id_r  <= e_id;
              out_pay_r <= PAY_W'(e_dat);
            end else begin
              out_status_r <= ST_NONE;
            end
          end
          default: out_id_r <= '0;
        endcase
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_event_id      = out_id_r;
  assign out_event_payload = out_pay_r;

  `PEP_ASSERT(a_commit_room, clk, rst_n, cmd.commit |-> (!out_valid_r || out_ready), "commit without room")
  `PEP_ASSERT_NEVER(a_step_and_commit, clk, rst_n, cmd.scan_step && cmd.commit, "scan during commit")
  `PEP_ASSERT(a_insert_fills, clk, rst_n, ram_we |=> used_r[$past(free_loc)], "insert slot not marked used")
  `PEP_ASSERT_NEVER(a_count_range, clk, rst_n, 32'(cnt_r[0]) > ID_LIMIT, "owner count past limit")
endmodule

// ===== rtl/per_owner_event_pool_top.sv =====
// Event pool for four owners over sixteen shared slots. One request is handled at a time:
// a check cycle, then insert and get sweep all slots once through the slot store (one
// read per cycle) and get reads the chosen slot again, while remove reads only its own
// slot and refused requests go straight from the check to the result beat.
// The single read port of the slot store paces the sweep. A new request is taken in
// the cycle after the result is registered, while that result may still wait to be taken.
// Every request gives exactly one result beat. The slot store needs no clearing pass.
module per_owner_event_pool_top (
  input logic       clk,
  input logic       rst_n,
  pep_in_if.sink    in_ch,
  pep_out_if.source out_ch
);
  import pep_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pep_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pep_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_req_type       (in_ch.req_type),
    .in_owner          (in_ch.owner),
    .in_payload        (in_ch.payload),
    .in_slot           (in_ch.slot),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_status        (out_ch.status),
    .out_event_id      (out_ch.event_id),
    .out_event_payload (out_ch.event_payload)
  );
endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the per-owner event pool
`timescale 1ns / 1ps

module tb_top;
  import pep_pkg::*;

  typedef struct {
    req_t                  rtype;
    logic [OWN_W-1:0]  owner;
    logic [PAY_W-1:0]  payload;
    logic [SLOT_W-1:0] slot;
  } pool_req_t;

  typedef struct {
    status_t          status;
    logic [ID_W-1:0]  event_id;
    logic [PAY_W-1:0] event_payload;
  } pool_resp_t;

  logic clk;
  logic rst_n;

  pep_in_if  req_bus ();
  pep_out_if resp_bus ();

  per_owner_event_pool_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_bus),
    .out_ch (resp_bus)
  );

  // shadow copy of the pool
  bit               slot_busy [POOL_SLOTS];
  logic [OWN_W-1:0] slot_who  [POOL_SLOTS];
  int               slot_id   [POOL_SLOTS];
  logic [PAY_W-1:0] slot_pay  [POOL_SLOTS];
  int               held_cnt  [OWNER_COUNT];
  int               get_cursor[OWNER_COUNT];

  pool_req_t  pending_reqs[$];
  pool_resp_t expected_resps[$];
  int         mismatches = 0;
  int         taken_reqs = 0;
  bit         req_took = 0;
  bit         calm;

  // highest id of an owner in [lo, hi), -1 when none
  function automatic int top_id(logic [OWN_W-1:0] who, int lo, int hi);
    int best;
    best = -1;
    for (int s = 0; s < POOL_SLOTS; s++)
      if (slot_busy[s] && slot_who[s] == who && slot_id[s] > best &&
          slot_id[s] >= lo && slot_id[s] < hi)
        best = slot_id[s];
    return best;
  endfunction

  // lowest id of an owner at or above lo, -1 when none
  function automatic int low_id(logic [OWN_W-1:0] who, int lo);
    int best;
    best = -1;
    for (int s = 0; s < POOL_SLOTS; s++)
      if (slot_busy[s] && slot_who[s] == who && slot_id[s] >= lo &&
          (best < 0 || slot_id[s] < best))
        best = slot_id[s];
    return best;
  endfunction

  function automatic void release_slot(int s);
    slot_busy[s] = 0;
    if (held_cnt[slot_who[s]] > 0) held_cnt[slot_who[s]]--;
  endfunction

  // apply one request to the shadow pool and return its response
  function automatic pool_resp_t pool_apply(pool_req_t r);
    pool_resp_t res;
    int cur;
    int id;
    int loc;
    res = '{ST_OK, '0, '0};
    loc = -1;
    case (r.rtype)
      REQ_INSERT: begin
        if (held_cnt[r.owner] >= ID_LIMIT) begin
          res.status = ST_LIMIT;
        end else begin
          for (int s = POOL_SLOTS - 1; s >= 0; s--)
            if (!slot_busy[s]) loc = s;
          if (loc < 0) begin
            res.status = ST_FULL;
          end else begin
            cur = get_cursor[r.owner];
            id = top_id(r.owner, cur, ID_LIMIT);
            if (id + 1 < ID_LIMIT) id = id + 1;
            else id = top_id(r.owner, 0, cur) + 1;
            slot_busy[loc] = 1;
            slot_who[loc] = r.owner;
            slot_id[loc] = id;
            slot_pay[loc] = r.payload;
            held_cnt[r.owner]++;
            res.event_id = id[ID_W-1:0];
          end
        end
      end
      REQ_GET: begin
        if (held_cnt[r.owner] == 0) begin
          res.status = ST_NONE;
        end else begin
          cur = get_cursor[r.owner];
          id = low_id(r.owner, cur);
          if (id < 0) begin
            cur = 0;
            id = low_id(r.owner, 0);
          end else begin
            cur = cur + 1;
          end
          if (id >= 0)
            for (int s = POOL_SLOTS - 1; s >= 0; s--)
              if (slot_busy[s] && slot_who[s] == r.owner && slot_id[s] == id) loc = s;
          if (loc < 0) begin
            res.status = ST_NONE;
          end else begin
            get_cursor[r.owner] = (cur >= ID_LIMIT) ? 0 : cur;
            res.event_id = slot_id[loc][ID_W-1:0];
            res.event_payload = slot_pay[loc];
            release_slot(loc);
          end
        end
      end
      REQ_REMOVE: begin
        if (!slot_busy[r.slot]) res.status = ST_FREE;
        else release_slot(r.slot);
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic pool_req_t mk_req(req_t t, int who, logic [PAY_W-1:0] pay, int s);
    pool_req_t r;
    r.rtype = t;
    r.owner = who[OWN_W-1:0];
    r.payload = pay;
    r.slot = s[SLOT_W-1:0];
    return r;
  endfunction

  // clock and reset
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    req_bus.valid = 0;
    req_bus.req_type = REQ_NOP;
    req_bus.owner = '0;
    req_bus.payload = '0;
    req_bus.slot = '0;
    resp_bus.ready = 0;
    repeat (10) @(negedge clk);
    rst_n = 1;
  end

  // no idling on either side in this window
  assign calm = (taken_reqs >= 400 && taken_reqs < 550);

  // request driver
  always @(negedge clk) begin
    bit took;
    took = req_took;
    if (rst_n) begin
      if (took) begin
        pending_reqs.pop_front();
        req_took = 0;
      end
      if (req_bus.valid && !took) begin
        // hold the current beat until it is taken
      end else if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 34)) begin
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= pending_reqs[0].rtype;
        req_bus.owner    <= pending_reqs[0].owner;
        req_bus.payload  <= pending_reqs[0].payload;
        req_bus.slot     <= pending_reqs[0].slot;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // response ready with one long hold-off
  int  holdoff_left = 0;
  bit  holdoff_done = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!holdoff_done && taken_reqs >= 700) begin
        holdoff_done <= 1;
        holdoff_left <= 300;
        resp_bus.ready <= 1'b0;
      end else if (holdoff_left > 0) begin
        holdoff_left <= holdoff_left - 1;
        resp_bus.ready <= 1'b0;
      end else begin
        resp_bus.ready <= calm || ($urandom_range(99) >= 34);
      end
    end
  end

  // monitor: predict on request beats, check response beats
  always @(posedge clk) begin
    pool_req_t  r;
    pool_resp_t want;
    if (rst_n) begin
      if (req_bus.valid && req_bus.ready) begin
        r.rtype   = req_t'(req_bus.req_type);
        r.owner   = req_bus.owner;
        r.payload = req_bus.payload;
        r.slot    = req_bus.slot;
        expected_resps.push_back(pool_apply(r));
        taken_reqs++;
        req_took = 1;
      end
      if (resp_bus.valid && resp_bus.ready) begin
        if (expected_resps.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected response beat: status %0d id %0d payload %h",
                     resp_bus.status, resp_bus.event_id, resp_bus.event_payload);
          mismatches++;
        end else begin
          want = expected_resps.pop_front();
          if (resp_bus.status !== want.status || resp_bus.event_id !== want.event_id ||
              resp_bus.event_payload !== want.event_payload) begin
            if (mismatches < 10)
              $display("mismatch: expected %0d/%0d/%h got %0d/%0d/%h",
                       want.status, want.event_id, want.event_payload,
                       resp_bus.status, resp_bus.event_id, resp_bus.event_payload);
            mismatches++;
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int pick;
    req_t t;
    foreach (slot_busy[s]) slot_busy[s] = 0;
    foreach (held_cnt[o]) begin
      held_cnt[o] = 0;
      get_cursor[o] = 0;
    end
    // directed: field extremes, every request, empty get, free slot, unknown request
    pending_reqs.push_back(mk_req(REQ_INSERT, 0, 32'h0000_0000, 0));
    pending_reqs.push_back(mk_req(REQ_INSERT, 1, 32'hffff_ffff, 15));
    pending_reqs.push_back(mk_req(REQ_GET, 3, 32'hffff_ffff, 15));
    pending_reqs.push_back(mk_req(REQ_GET, 0, 32'h0, 0));
    pending_reqs.push_back(mk_req(REQ_REMOVE, 0, 32'h0, 15));
    pending_reqs.push_back(mk_req(REQ_REMOVE, 3, 32'h0, 1));
    pending_reqs.push_back(mk_req(REQ_NOP, 3, 32'hffff_ffff, 15));
    // one owner fills the pool, then owner limit and pool full
    for (int i = 0; i < POOL_SLOTS; i++)
      pending_reqs.push_back(mk_req(REQ_INSERT, 2, $urandom, 0));
    pending_reqs.push_back(mk_req(REQ_INSERT, 2, 32'h1234_5678, 0));
    pending_reqs.push_back(mk_req(REQ_INSERT, 3, 32'h8765_4321, 0));
    // random mix weighted toward insert and get
    for (int i = 0; i < 1050; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) t = REQ_INSERT;
      else if (pick < 80) t = REQ_GET;
      else if (pick < 95) t = REQ_REMOVE;
      else t = REQ_NOP;
      pending_reqs.push_back(mk_req(t, $urandom_range(OWNER_COUNT - 1), $urandom,
                                    $urandom_range(POOL_SLOTS - 1)));
    end
    wait (rst_n);
    while (pending_reqs.size() != 0 || req_bus.valid || expected_resps.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (expected_resps.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
